@@ rtl/core/mhpq_pkg.sv @@
// shared types and constants for the max-heap priority queue
package mhpq_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 7;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SORT   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_SR_RD,
    S_SR_CMP,
    S_DEL_LAST,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DN_DEC,
    S_SORT_RD,
    S_SORT_TOP,
    S_SORT_LAST,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic we;
    cnt_t waddr;
    key_t wdata;
    logic re;
    cnt_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic    valid;
    key_t    value;
    status_t status;
    logic    last;
    cnt_t    count;
  } result_t;

endpackage

@@ rtl/core/mhpq_ram.sv @@
// heap key store, one write port and one registered read port
module mhpq_ram #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  mhpq_pkg::mem_req_t req,
  output mhpq_pkg::key_t     rd_data
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  key_t mem [DEPTH];
  key_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/mhpq_ctrl.sv @@
// operation sequencer: insert, search and delete, sort drain, hole-based sifts
module mhpq_ctrl #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  mhpq_pkg::key_t     in_key,
  input  logic               emit_ready,
  output mhpq_pkg::result_t  emit,
  output mhpq_pkg::mem_req_t mem_req,
  input  mhpq_pkg::key_t     rd_data
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = CNT_W + 1;

  state_t          state_r, state_nxt;
  cnt_t            cnt_r, cnt_nxt;
  logic [AW-1:0]   i_r, i_nxt;
  logic [AW-1:0]   j_r, j_nxt;
  logic [AW-1:0]   big_r, big_nxt;
  key_t            cur_r, cur_nxt;
  key_t            bv_r, bv_nxt;
  key_t            key_r, key_nxt;
  key_t            res_val_r, res_val_nxt;
  status_t         res_st_r, res_st_nxt;
  logic            sort_r, sort_nxt;

  logic [CW-1:0]   l_ext, r_ext, cnt_ext, j_ext;
  logic [AW-1:0]   parent;
  logic            l_ok, r_ok, up_move, found, search_end, full;
  op_t             op;

  assign op         = op_t'(in_op);
  assign l_ext      = CW'({i_r, 1'b1});
  assign r_ext      = l_ext + CW'(1);
  assign cnt_ext    = CW'(cnt_r);
  assign j_ext      = CW'(j_r) + CW'(1);
  assign l_ok       = l_ext < cnt_ext;
  assign r_ok       = r_ext < cnt_ext;
  assign parent     = AW'((i_r - 1'b1) >> 1);
  assign up_move    = rd_data < cur_r;
  assign found      = rd_data == key_r;
  assign search_end = j_ext >= cnt_ext;
  assign full       = cnt_r >= CNT_W'(CAPACITY);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_INSERT: state_nxt = full ? S_EMIT : S_UP;
            OP_DELETE: state_nxt = (cnt_r == '0) ? S_EMIT : S_SR_RD;
            OP_SORT:   state_nxt = (cnt_r == '0) ? S_EMIT : S_SORT_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_UP:        state_nxt = (i_r == '0) ? S_EMIT : S_UP_CMP;
      S_UP_CMP:    state_nxt = up_move ? S_UP : S_EMIT;
      S_SR_RD:     state_nxt = S_SR_CMP;
      S_SR_CMP: begin
        if (found) begin
          state_nxt = (j_ext < cnt_ext) ? S_DEL_LAST : S_EMIT;
        end else begin
          state_nxt = search_end ? S_EMIT : S_SR_RD;
        end
      end
      S_DEL_LAST:  state_nxt = S_DN;
      S_DN: begin
        if (l_ok) begin
          state_nxt = S_DN_L;
        end else begin
          state_nxt = sort_r ? S_EMIT : S_UP;
        end
      end
      S_DN_L:      state_nxt = r_ok ? S_DN_R : S_DN_DEC;
      S_DN_R:      state_nxt = S_DN_DEC;
      S_DN_DEC: begin
        if (big_r != i_r) begin
          state_nxt = S_DN;
        end else begin
          state_nxt = sort_r ? S_EMIT : S_UP;
        end
      end
      S_SORT_RD:   state_nxt = S_SORT_TOP;
      S_SORT_TOP:  state_nxt = (cnt_r > CNT_W'(1)) ? S_SORT_LAST : S_EMIT;
      S_SORT_LAST: state_nxt = S_DN;
      S_EMIT: begin
        if (emit_ready) begin
          state_nxt = (sort_r && cnt_r != '0) ? S_SORT_RD : S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    big_nxt     = big_r;
    cur_nxt     = cur_r;
    bv_nxt      = bv_r;
    key_nxt     = key_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    sort_nxt    = sort_r;
    mem_req     = '0;
    emit        = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt     = in_key;
          res_val_nxt = in_key;
          res_st_nxt  = ST_OK;
          sort_nxt    = 1'b0;
          case (op)
            OP_INSERT: begin
              if (full) begin
                res_st_nxt = ST_FULL;
              end else begin
                i_nxt   = AW'(cnt_r);
                cnt_nxt = cnt_r + CNT_W'(1);
                cur_nxt = in_key;
              end
            end
            OP_DELETE: begin
              j_nxt = '0;
              if (cnt_r == '0) begin
                res_st_nxt = ST_NOT_FOUND;
              end
            end
            OP_SORT: begin
              if (cnt_r == '0) begin
                res_val_nxt = '0;
                res_st_nxt  = ST_EMPTY;
              end else begin
                sort_nxt = 1'b1;
              end
            end
            default: begin
              res_st_nxt = res_st_r;
            end
          endcase
        end
      end
      S_UP: begin
        if (i_r == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = CNT_W'(i_r);
          mem_req.wdata = cur_r;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = CNT_W'(parent);
        end
      end
      S_UP_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = CNT_W'(i_r);
        if (up_move) begin
          mem_req.wdata = rd_data;
          i_nxt         = parent;
        end else begin
          mem_req.wdata = cur_r;
        end
      end
      S_SR_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = CNT_W'(j_r);
      end
      S_SR_CMP: begin
        if (found) begin
          i_nxt   = j_r;
          cnt_nxt = cnt_r - CNT_W'(1);
          if (j_ext < cnt_ext) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = cnt_r - CNT_W'(1);
          end
        end else if (search_end) begin
          res_st_nxt = ST_NOT_FOUND;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DEL_LAST: begin
        cur_nxt = rd_data;
      end
      S_DN: begin
        if (l_ok) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = CNT_W'(l_ext);
        end else if (sort_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = CNT_W'(i_r);
          mem_req.wdata = cur_r;
        end
      end
      S_DN_L: begin
        if (cur_r < rd_data) begin
          big_nxt = AW'(l_ext);
          bv_nxt  = rd_data;
        end else begin
          big_nxt = i_r;
          bv_nxt  = cur_r;
        end
        if (r_ok) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = CNT_W'(r_ext);
        end
      end
      S_DN_R: begin
        if (bv_r < rd_data) begin
          big_nxt = AW'(r_ext);
          bv_nxt  = rd_data;
        end
      end
      S_DN_DEC: begin
        if (big_r != i_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = CNT_W'(i_r);
          mem_req.wdata = bv_r;
          i_nxt         = big_r;
        end else if (sort_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = CNT_W'(i_r);
          mem_req.wdata = cur_r;
        end
      end
      S_SORT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = '0;
      end
      S_SORT_TOP: begin
        res_val_nxt = rd_data;
        res_st_nxt  = ST_OK;
        cnt_nxt     = cnt_r - CNT_W'(1);
        if (cnt_r > CNT_W'(1)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = cnt_r - CNT_W'(1);
        end
      end
      S_SORT_LAST: begin
        cur_nxt = rd_data;
        i_nxt   = '0;
      end
      S_EMIT: begin
        emit.valid  = 1'b1;
        emit.value  = res_val_r;
        emit.status = res_st_r;
        emit.last   = sort_r ? (cnt_r == '0) : 1'b1;
        emit.count  = cnt_r;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sort_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sort_r  <= sort_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    big_r     <= big_nxt;
    cur_r     <= cur_nxt;
    bv_r      <= bv_nxt;
    key_r     <= key_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
  end

endmodule

@@ rtl/core/max_heap_priority_queue.sv @@
// top level of the max-heap priority queue with result register
// Usage:
// The in_ channel carries one command per transfer: in_tuser is the opcode
// (insert, delete first matching key, sort drain) and in_tdata the key.
// The out_ channel returns the results; out_tlast marks the last result of a
// command, out_tuser is the status and out_tdata holds the value and count.
// One command is worked on at a time; in_tready is high only while idle.
// Steps per command:
//   insert: one read and one write per level walked up
//   delete: one read per key compared, then a fetch of the last key, up to
//     two reads and a write per level down, and a read and a write per level up
//   sort drain: per key emitted, a read of the top and of the last key,
//     then the sift down. The key store has a single registered read port.
// An unused opcode is taken and dropped.
// A finished result sits in an output register; while the receiver stalls,
// the sequencer waits on it, and the next command is taken as soon as the
// last result is in that register. Reset empties the heap.
module max_heap_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // key
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // value, count, zero pad
  output logic [1:0]  out_tuser,  // status
  output logic        out_tlast   // last
);
  import mhpq_pkg::*;

  mem_req_t mem_req;
  key_t     rd_data;
  result_t  emit;
  logic     emit_ready;

  logic     out_valid_r;
  key_t     out_val_r;
  status_t  out_st_r;
  logic     out_last_r;
  cnt_t     out_cnt_r;

  assign emit_ready = !out_valid_r || out_tready;

  mhpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_key     (key_t'(in_tdata)),
    .emit_ready (emit_ready),
    .emit       (emit),
    .mem_req    (mem_req),
    .rd_data    (rd_data)
  );

  mhpq_ram #(
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid && emit_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid && emit_ready) begin
      out_val_r  <= emit.value;
      out_st_r   <= emit.status;
      out_last_r <= emit.last;
      out_cnt_r  <= emit.count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_val_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready &&
     (in_tuser == OP_INSERT || in_tuser == OP_DELETE || in_tuser == OP_SORT))
    |=> !in_tready)
    else $error("command taken while the sequencer stayed idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[38:32] <= CNT_W'(CAPACITY)))
    else $error("result count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FULL) |-> (out_tdata[38:32] == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_EMPTY) |-> (out_tlast && out_tdata[38:0] == '0))
    else $error("empty status with data or without last");

endmodule

@@ sim/tb_max_heap_priority_queue.sv @@
// self-checking testbench for the max-heap priority queue over its stream ports
module tb_max_heap_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  localparam int CAPACITY = 64;
  localparam int ITEMS = 260;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 200;
  localparam int LIMIT_CYCLES = 500000;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam key_t KEY_MAX = 32'sh7FFFFFFF;
  localparam key_t KEY_MIN = 32'sh80000000;

  typedef struct {
    key_t    value;
    status_t status;
    logic    last;
    cnt_t    count;
  } heap_result_t;

  typedef struct packed {
    logic [1:0] opc;
    key_t       key;
    logic       typed;
    key_t       x_value;
    status_t    x_status;
    cnt_t       x_count;
  } step_t;

  localparam step_t DIRECTED [25] = '{
    '{OP_SORT,   32'sd0,         1'b1, 32'sd0,         ST_EMPTY,     7'd0},
    '{OP_DELETE, 32'sd5,         1'b1, 32'sd5,         ST_NOT_FOUND, 7'd0},
    '{OP_NONE,   32'sd7,         1'b0, 32'sd0,         ST_OK,        7'd0},
    '{OP_INSERT, KEY_MAX,        1'b1, KEY_MAX,        ST_OK,        7'd1},
    '{OP_INSERT, KEY_MIN,        1'b1, KEY_MIN,        ST_OK,        7'd2},
    '{OP_INSERT, 32'sd0,         1'b1, 32'sd0,         ST_OK,        7'd3},
    '{OP_INSERT, -32'sd1,        1'b1, -32'sd1,        ST_OK,        7'd4},
    '{OP_INSERT, 32'sd1,         1'b1, 32'sd1,         ST_OK,        7'd5},
    '{OP_INSERT, 32'sd1,         1'b1, 32'sd1,         ST_OK,        7'd6},
    '{OP_INSERT, 32'sh55555555,  1'b1, 32'sh55555555,  ST_OK,        7'd7},
    '{OP_INSERT, 32'shAAAAAAAA,  1'b1, 32'shAAAAAAAA,  ST_OK,        7'd8},
    '{OP_DELETE, 32'sd1,         1'b1, 32'sd1,         ST_OK,        7'd7},
    '{OP_DELETE, 32'sd42,        1'b1, 32'sd42,        ST_NOT_FOUND, 7'd7},
    '{OP_DELETE, KEY_MAX,        1'b1, KEY_MAX,        ST_OK,        7'd6},
    '{OP_DELETE, KEY_MIN,        1'b1, KEY_MIN,        ST_OK,        7'd5},
    '{OP_NONE,   -32'sd1,        1'b0, 32'sd0,         ST_OK,        7'd0},
    '{OP_SORT,   -32'sd1,        1'b0, 32'sd0,         ST_OK,        7'd0},
    '{OP_SORT,   32'sd0,         1'b1, 32'sd0,         ST_EMPTY,     7'd0},
    '{OP_INSERT, 32'sd3,         1'b1, 32'sd3,         ST_OK,        7'd1},
    '{OP_INSERT, 32'sd3,         1'b1, 32'sd3,         ST_OK,        7'd2},
    '{OP_INSERT, 32'sd3,         1'b1, 32'sd3,         ST_OK,        7'd3},
    '{OP_INSERT, 32'sd9,         1'b1, 32'sd9,         ST_OK,        7'd4},
    '{OP_DELETE, 32'sd3,         1'b1, 32'sd3,         ST_OK,        7'd3},
    '{OP_DELETE, 32'sd9,         1'b1, 32'sd9,         ST_OK,        7'd2},
    '{OP_SORT,   32'sd0,         1'b0, 32'sd0,         ST_OK,        7'd0}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // key
  logic [1:0]  in_tuser = '0;   // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // value, count, zero pad
  logic [1:0]  out_tuser;       // status
  logic        out_tlast;

  key_t         heap_keys [CAPACITY];
  int           heap_len = 0;
  heap_result_t pending_results [$];

  int err_count = 0;
  int cmds_sent = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int rx_tick = 0;
  int rx_mode = 0;
  int cycle_count = 0;

  max_heap_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // heap predictor
  function automatic void swap_keys(int a, int b);
    key_t t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void float_up(int i);
    int p;
    while (i > 0 && i < heap_len) begin
      p = (i - 1) / 2;
      if (!(heap_keys[p] < heap_keys[i])) break;
      swap_keys(i, p);
      i = p;
    end
  endfunction

  function automatic int sink_down(int i);
    int big;
    int l;
    int r;
    while (i < heap_len) begin
      big = i;
      l = 2 * i + 1;
      r = 2 * i + 2;
      if (l < heap_len && heap_keys[big] < heap_keys[l]) big = l;
      if (r < heap_len && heap_keys[big] < heap_keys[r]) big = r;
      if (big == i) break;
      swap_keys(i, big);
      i = big;
    end
    return i;
  endfunction

  function automatic void push_result(key_t v, status_t s, logic l);
    pending_results.push_back('{value: v, status: s, last: l, count: cnt_t'(heap_len)});
  endfunction

  function automatic void apply_cmd(logic [1:0] opc, key_t key);
    int i;
    key_t top;
    case (opc)
      OP_INSERT: begin
        if (heap_len >= CAPACITY) begin
          push_result(key, ST_FULL, 1'b1);
        end else begin
          heap_keys[heap_len] = key;
          heap_len++;
          float_up(heap_len - 1);
          push_result(key, ST_OK, 1'b1);
        end
      end
      OP_DELETE: begin
        i = 0;
        while (i < heap_len && heap_keys[i] !== key) i++;
        if (i >= heap_len) begin
          push_result(key, ST_NOT_FOUND, 1'b1);
        end else begin
          heap_len--;
          if (i < heap_len) begin
            heap_keys[i] = heap_keys[heap_len];
            float_up(sink_down(i));
          end
          push_result(key, ST_OK, 1'b1);
        end
      end
      OP_SORT: begin
        if (heap_len == 0) begin
          push_result(32'sd0, ST_EMPTY, 1'b1);
        end else begin
          while (heap_len > 0) begin
            top = heap_keys[0];
            heap_len--;
            if (heap_len > 0) begin
              heap_keys[0] = heap_keys[heap_len];
              void'(sink_down(0));
            end
            push_result(top, ST_OK, heap_len == 0);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // sender: bursts with random gaps, valid held across back-to-back transfers
  task automatic send_cmd(logic [1:0] opc, key_t key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= opc;
    in_tdata <= key;
    do @(posedge clk); while (!in_tready);
    apply_cmd(opc, key);
    if (opc != OP_NONE) cmds_sent++;
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return key_t'($urandom);
      4, 5, 6: return key_t'(int'($urandom_range(0, 15)) - 8);
      7: begin
        case ($urandom_range(0, 3))
          0: return KEY_MAX;
          1: return KEY_MIN;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: begin
        if (heap_len > 0) return heap_keys[$urandom_range(0, heap_len - 1)];
        return key_t'($urandom);
      end
    endcase
  endfunction

  task automatic mixed_run();
    int n;
    int r;
    n = $urandom_range(4, 20);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 50 || (r < 75 && heap_len == 0)) begin
        send_cmd(OP_INSERT, pick_key());
      end else if (r < 75) begin
        send_cmd(OP_DELETE, heap_keys[$urandom_range(0, heap_len - 1)]);
      end else if (r < 85) begin
        send_cmd(OP_DELETE, pick_key());
      end else if (r < 90) begin
        send_cmd(OP_NONE, key_t'($urandom));
      end else begin
        send_cmd(OP_SORT, key_t'($urandom));
      end
    end
    if ($urandom_range(0, 2) == 0) send_cmd(OP_SORT, key_t'($urandom));
  endtask

  // fill to capacity, push past it while the receiver holds off, then drain
  task automatic fill_run();
    while (heap_len < CAPACITY) send_cmd(OP_INSERT, pick_key());
    hold_req = 1'b1;
    repeat (3) send_cmd(OP_INSERT, pick_key());
    send_cmd(OP_DELETE, heap_keys[$urandom_range(0, CAPACITY - 1)]);
    send_cmd(OP_INSERT, pick_key());
    send_cmd(OP_INSERT, pick_key());
    send_cmd(OP_DELETE, pick_key());
    send_cmd(OP_SORT, key_t'($urandom));
  endtask

  initial begin
    bit filled;
    filled = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[n]) begin
      send_cmd(DIRECTED[n].opc, DIRECTED[n].key);
      if (DIRECTED[n].typed)
        pending_results[pending_results.size() - 1] = '{value: DIRECTED[n].x_value,
          status: DIRECTED[n].x_status, last: 1'b1, count: DIRECTED[n].x_count};
    end
    while (cmds_sent < ITEMS) begin
      if (!filled && cmds_sent >= 90) begin
        fill_run();
        filled = 1'b1;
      end else begin
        mixed_run();
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_max_heap_priority_queue: done, clean");
    end else begin
      $display("tb_max_heap_priority_queue: done, errors");
    end
    $finish;
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (rx_tick % 3 == 0);
      endcase
    end
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("%0t: result %s mismatch, got %0h, expected %0h", $realtime, field, got, want);
  endtask

  always @(posedge clk) begin : result_check
    heap_result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("transfer unexpected", out_tdata[31:0], 32'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_tdata[31:0] !== w.value) report_mismatch("value", out_tdata[31:0], w.value);
        if (out_tuser !== w.status)
          report_mismatch("status", 32'(out_tuser), 32'(w.status));
        if (out_tlast !== w.last)
          report_mismatch("last", 32'(out_tlast), 32'(w.last));
        if (out_tdata[38:32] !== w.count)
          report_mismatch("count", 32'(out_tdata[38:32]), 32'(w.count));
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_max_heap_priority_queue: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_ram.sv
rtl/core/mhpq_ctrl.sv
rtl/core/max_heap_priority_queue.sv
sim/tb_max_heap_priority_queue.sv
